// ----- hdl/iads_pkg.sv -----
// shared types and constants of the absolute difference statistics unit
package iads_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 40;
    localparam int MEAN_W   = 24;
    localparam int FRAC_W   = 8;
    localparam int MINMAX_W = 16;

    localparam int PIXEL_BITS_DEF      = 16;
    localparam int MAX_PIXELS_LOG2_DEF = 24;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ref_sample;
        logic [SAMPLE_W-1:0] test_sample;
        logic                last_sample;
    } t_in_beat;

    typedef struct packed {
        logic [SUM_W-1:0]    sum_abs_diff;
        logic [MINMAX_W-1:0] min_diff;
        logic [MINMAX_W-1:0] max_diff;
        logic [MEAN_W-1:0]   mean_diff;
    } t_out_beat;

    // controller to datapath
    typedef struct packed {
        logic acc_en;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ----- hdl/iads_ctrl.sv -----
// sequencing of accumulation, mean division and result hand-off
module iads_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  iads_pkg::t_status i_status,
    output logic             o_in_ready,
    output iads_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_ACC  = 2'd0;
    localparam logic [1:0] S_INIT = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    localparam int DIV_STEPS = iads_pkg::MEAN_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_ACC: begin
                o_in_ready   = 1'b1;
                o_cmd.acc_en = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ----- hdl/iads_dp.sv -----
// accumulators, bit-serial mean divider and output register
module iads_dp #(
    parameter int PIXEL_BITS      = iads_pkg::PIXEL_BITS_DEF,
    parameter int MAX_PIXELS_LOG2 = iads_pkg::MAX_PIXELS_LOG2_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iads_pkg::t_cmd      i_cmd,
    input  iads_pkg::t_in_beat  i_in_data,
    input  logic                i_out_ready,
    output iads_pkg::t_status   o_status,
    output logic                o_out_valid,
    output iads_pkg::t_out_beat o_out_data
);

    localparam int SUM_W  = iads_pkg::SUM_W;
    localparam int MEAN_W = iads_pkg::MEAN_W;
    localparam int CW     = MAX_PIXELS_LOG2 + 1;
    localparam int SHW    = 16;  // sum >= count * 2^16 means mean overflows 24 bits
    localparam int CMPW   = (CW + SHW > SUM_W) ? CW + SHW : SUM_W;
    localparam int LOW_W  = MEAN_W;  // dividend bits shifted in during division
    localparam logic [CW-1:0] CNT_MAX = CW'(1) << MAX_PIXELS_LOG2;

    logic [PIXEL_BITS-1:0] a, b, d;
    logic [SUM_W:0]        sum_ext;

    logic [SUM_W-1:0]      r_sum;
    logic [PIXEL_BITS-1:0] r_min, r_max;
    logic [CW-1:0]         r_cnt;

    logic [CW-1:0]         r_rem;
    logic [LOW_W-1:0]      r_low;
    logic [MEAN_W-1:0]     r_quot;
    logic                  r_sat;
    logic [CW:0]           rem2;
    logic [CW:0]           rem_sub;

    logic                  r_out_valid;
    iads_pkg::t_out_beat   r_out;

    assign a       = i_in_data.ref_sample[PIXEL_BITS-1:0];
    assign b       = i_in_data.test_sample[PIXEL_BITS-1:0];
    assign d       = (a >= b) ? (a - b) : (b - a);
    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(d);

    assign rem2    = {r_rem, r_low[LOW_W-1]};
    assign rem_sub = rem2 - {1'b0, r_cnt};

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_sum <= '0;
            r_min <= '1;
            r_max <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc_en) begin
            r_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            if (d < r_min) begin
                r_min <= d;
            end
            if (d > r_max) begin
                r_max <= d;
            end
            if (r_cnt < CNT_MAX) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // restoring division of sum * 256 by count, high part preloaded
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_sat  <= CMPW'(r_sum) >= (CMPW'(r_cnt) << SHW);
            r_rem  <= CW'(r_sum[SUM_W-1:SHW]);
            r_low  <= {r_sum[SHW-1:0], {iads_pkg::FRAC_W{1'b0}}};
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_low <= r_low << 1;
            if (rem2 >= {1'b0, r_cnt}) begin
                r_rem  <= rem_sub[CW-1:0];
                r_quot <= {r_quot[MEAN_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem2[CW-1:0];
                r_quot <= {r_quot[MEAN_W-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.sum_abs_diff <= r_sum;
            r_out.min_diff     <= iads_pkg::MINMAX_W'(r_min);
            r_out.max_diff     <= iads_pkg::MINMAX_W'(r_max);
            r_out.mean_diff    <= r_sat ? '1 : r_quot;
        end
    end

endmodule

// ----- hdl/image_abs_diff_statistics_unit.sv -----
// top level of the image absolute difference statistics unit
// throughput: one sample beat per cycle within a plane
// after its last sample beat a plane passes a setup state, the steps of the bit-serial
// mean divider and a load state, which waits until the output register is free
// input is held off from setup until the load, so also while a previous result is untaken
// reset: synchronous active low, clears accumulators, controller and output valid
module image_abs_diff_statistics_unit #(
    parameter int PIXEL_BITS      = iads_pkg::PIXEL_BITS_DEF,
    parameter int MAX_PIXELS_LOG2 = iads_pkg::MAX_PIXELS_LOG2_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // sample beats
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  iads_pkg::t_in_beat  i_in_data,
    // plane result beats
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output iads_pkg::t_out_beat o_out_data
);

    // command and status between the sequencer and the datapath
    iads_pkg::t_cmd    cmd;
    iads_pkg::t_status status;

    // sequencer: accumulate, then set up and step the divider, then hand off
    iads_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last_sample),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // datapath: running sum, min, max, count, divider and result register
    iads_dp #(
        .PIXEL_BITS      (PIXEL_BITS),
        .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
